// File: src/cnls_pkg.sv
// Package for the character LCD nibble sequencer.
// Holds the item codes, the queue word types and the display tables.
// No dependencies; every other file of the block imports it.
package cnls_pkg;

  // Width of the wait counter and its largest value.
  localparam int DELAY_BITS = 16;
  localparam logic [31:0] COUNT_MAX = (32'd1 << DELAY_BITS) - 32'd1;

  // Action codes on the input channel.
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_COMMAND = 3'd1;
  localparam logic [2:0] ACT_DATA    = 3'd2;
  localparam logic [2:0] ACT_INIT    = 3'd3;
  localparam logic [2:0] ACT_GOTO    = 3'd4;
  localparam logic [2:0] ACT_CLEAR   = 3'd5;

  // Classified item kinds passed from the front end to the sequencer.
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_COMMAND = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_INIT    = 3'd3;
  localparam logic [2:0] KIND_GOTO    = 3'd4;
  localparam logic [2:0] KIND_CLEAR   = 3'd5;
  localparam logic [2:0] KIND_INVALID = 3'd6;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_POWER  = 3'd1;
  localparam logic [2:0] PH_HI_EN  = 3'd2;
  localparam logic [2:0] PH_HI_GAP = 3'd3;
  localparam logic [2:0] PH_LO_EN  = 3'd4;
  localparam logic [2:0] PH_SETTLE = 3'd5;
  localparam logic [2:0] PH_EXTRA  = 3'd6;

  // Sequence modes.
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_GOTO   = 2'd1;
  localparam logic [1:0] MODE_INIT   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE_PULSE = 3'd0;
  localparam logic [2:0] REG_NIBBLE_GAP   = 3'd1;
  localparam logic [2:0] REG_SETTLE       = 3'd2;
  localparam logic [2:0] REG_COMMAND_GAP  = 3'd3;
  localparam logic [2:0] REG_POWER_UP     = 3'd4;

  localparam logic [3:0] INIT_LEN   = 4'd11;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_HOME   = 8'h80;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_val;
  } cmd_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       register_select;
    logic       enable_line;
    logic       busy_res;
    logic       rejected;
  } res_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h33;
      4'd1:    b = 8'h32;
      4'd2:    b = 8'h28;
      4'd3:    b = 8'h0C;
      4'd4:    b = 8'h01;
      4'd5:    b = 8'h06;
      4'd6:    b = 8'h02;
      4'd7:    b = 8'h28;
      4'd8:    b = 8'h0C;
      4'd9:    b = 8'h06;
      4'd10:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0: b = 8'h80;
      2'd1: b = 8'hC0;
      2'd2: b = 8'h94;
      2'd3: b = 8'hD4;
    endcase
    return b;
  endfunction

endpackage

// File: src/char_lcd_nibble_sequencer_unit.sv
// Character LCD nibble sequencer for a display in 4-bit mode, top level.
// Instantiates cnls_front, cnls_cmd_queue, cnls_back and cnls_res_queue; uses cnls_pkg.
//
// Usage: each input word is a one-microsecond tick or a request (command
// byte, data byte, power-up init, go-to row/column, clear). The input side
// is a queue: a word is taken when push is high and full is low.
// Every word yields exactly one result word holding the display pin levels
// (D4..D7, register select, enable), the busy flag and a rejected flag.
// Results are read like a queue: the oldest one is on the out_ ports while
// empty is low and leaves when pop is high.
//
// Throughput is one word per cycle while the result queue has room: the
// sequencer updates its phase, wait counter and sequence index once per
// word. An accepted word is registered in the classified-word queue; the
// sequencer takes it from there and writes its result into the result queue
// in the same cycle, and the result then waits on the out_ ports to be popped.
// When the receiver stalls the result queue fills, the sequencer stops,
// the word queue fills behind it and full rises; no word is dropped.
// Reset clears both queues and returns the sequencer to idle with all pins low
// and the timing registers at their defaults. The cfg_ port is always ready;
// the user must write registers only while the block is idle; nothing checks it.
module char_lcd_nibble_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic [2:0]  in_row,
  input  logic [4:0]  in_column,
  input  logic        push,
  output logic        full,
  output logic [3:0]  out_data_nibble,
  output logic        out_register_select,
  output logic        out_enable_line,
  output logic        out_busy_res,
  output logic        out_rejected,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cnls_pkg::*;

  cmd_t front_cmd, head_cmd;
  res_t back_res, out_res;
  logic cmd_full, cmd_not_empty, res_full, fire;

  cnls_front u_front (
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .cmd           (front_cmd)
  );

  cnls_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push && !cmd_full),
    .wr_data   (front_cmd),
    .full      (cmd_full),
    .rd_en     (fire),
    .not_empty (cmd_not_empty),
    .rd_data   (head_cmd)
  );

  // The sequencer runs one word whenever one waits and the result has room.
  assign fire = cmd_not_empty && !res_full;

  cnls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .cmd       (head_cmd),
    .res       (back_res),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cnls_res_queue u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fire),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (pop && !empty),
    .empty   (empty),
    .rd_data (out_res)
  );

  assign full                = cmd_full;
  assign cfg_ready           = 1'b1;
  assign out_data_nibble     = out_res.data_nibble;
  assign out_register_select = out_res.register_select;
  assign out_enable_line     = out_res.enable_line;
  assign out_busy_res        = out_res.busy_res;
  assign out_rejected        = out_res.rejected;

endmodule

// File: src/cnls_front.sv
// Front end of the LCD sequencer: classifies one input word.
// Depends on cnls_pkg for the action and kind codes and the row table.
module cnls_front (
  input  logic [2:0]    in_action,
  input  logic [7:0]    in_byte_value,
  input  logic [2:0]    in_row,
  input  logic [4:0]    in_column,
  output cnls_pkg::cmd_t cmd
);
  import cnls_pkg::*;

  logic [1:0] row_m1;

  assign row_m1 = in_row[1:0] - 2'd1;

  always_comb begin
    cmd.kind     = KIND_INVALID;
    cmd.byte_val = in_byte_value;
    unique case (in_action)
      ACT_TICK:    cmd.kind = KIND_TICK;
      ACT_COMMAND: cmd.kind = KIND_COMMAND;
      ACT_DATA:    cmd.kind = KIND_DATA;
      ACT_INIT:    cmd.kind = KIND_INIT;
      ACT_CLEAR:   cmd.kind = KIND_CLEAR;
      ACT_GOTO: begin
        // Rows are counted from one; anything outside one to four is refused.
        if (in_row >= 3'd1 && in_row <= 3'd4) begin
          cmd.kind = KIND_GOTO;
        end
        cmd.byte_val = row_base(row_m1) + {3'b000, in_column} - 8'd1;
      end
      default:     cmd.kind = KIND_INVALID;
    endcase
  end

endmodule

// File: src/cnls_cmd_queue.sv
// Two-entry queue of classified words between the front end and the sequencer.
// Depends on cnls_pkg for cmd_t.
module cnls_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cnls_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           not_empty,
  output cnls_pkg::cmd_t rd_data
);
  import cnls_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// File: src/cnls_res_queue.sv
// Two-entry result queue that decouples the sequencer from the receiver.
// Depends on cnls_pkg for res_t.
module cnls_res_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cnls_pkg::res_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           empty,
  output cnls_pkg::res_t rd_data
);
  import cnls_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// File: src/cnls_back.sv
// Back end of the LCD sequencer: timing registers, wait counter and phase logic.
// Executes one classified word per cycle when fire is high. Depends on cnls_pkg.
module cnls_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  cnls_pkg::cmd_t cmd,
  output cnls_pkg::res_t res,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import cnls_pkg::*;

  logic [7:0]            pulse_r;
  logic [15:0]           gap_r, settle_r, cgap_r, power_r;
  logic [2:0]            phase_r, phase_nxt;
  logic [DELAY_BITS-1:0] wait_r, wait_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [3:0]            idx_r, idx_nxt;
  logic [3:0]            nib_r, nib_nxt;
  logic                  sel_r, sel_nxt;
  logic                  en_r, en_nxt;
  logic                  rej;

  // Loads a duration into the counter, saturating at its largest value.
  function automatic logic [DELAY_BITS-1:0] sat(input logic [15:0] d);
    logic [31:0] dx;
    dx = 32'(d);
    if (dx > COUNT_MAX) begin
      return COUNT_MAX[DELAY_BITS-1:0];
    end
    return dx[DELAY_BITS-1:0];
  endfunction

  function automatic logic [15:0] at_least_one(input logic [15:0] d);
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  always_comb begin
    logic       start;
    logic [7:0] start_val;
    logic       extra_go;
    logic [15:0] d;
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    byte_nxt  = byte_r;
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    nib_nxt   = nib_r;
    sel_nxt   = sel_r;
    en_nxt    = en_r;
    rej       = 1'b0;
    start     = 1'b0;
    start_val = 8'h00;
    extra_go  = 1'b0;
    d         = 16'd0;

    if (cmd.kind == KIND_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (wait_r <= DELAY_BITS'(1)) begin
          wait_nxt = '0;
          unique case (phase_r)
            PH_POWER: begin
              idx_nxt   = 4'd0;
              sel_nxt   = 1'b0;
              start     = 1'b1;
              start_val = init_byte(4'd0);
            end
            PH_HI_EN: begin
              phase_nxt = PH_HI_GAP;
              en_nxt    = 1'b0;
              wait_nxt  = sat(at_least_one(gap_r));
            end
            PH_HI_GAP: begin
              phase_nxt = PH_LO_EN;
              nib_nxt   = byte_r[3:0];
              en_nxt    = 1'b1;
              wait_nxt  = sat(at_least_one({8'h00, pulse_r}));
            end
            PH_LO_EN: begin
              phase_nxt = PH_SETTLE;
              en_nxt    = 1'b0;
              wait_nxt  = sat(at_least_one(settle_r));
            end
            PH_SETTLE: begin
              if (mode_r == MODE_SINGLE) begin
                phase_nxt = PH_IDLE;
              end else begin
                d = (mode_r == MODE_CLEAR) ? at_least_one(settle_r) : cgap_r;
                phase_nxt = PH_EXTRA;
                // A zero command gap moves straight on to the next step.
                if (d != 16'd0) begin
                  wait_nxt = sat(d);
                end else begin
                  extra_go = 1'b1;
                end
              end
            end
            PH_EXTRA: extra_go = 1'b1;
            default:  phase_nxt = PH_IDLE;
          endcase
        end else begin
          wait_nxt = wait_r - DELAY_BITS'(1);
        end
      end
    end else if (phase_r != PH_IDLE || cmd.kind == KIND_INVALID) begin
      rej = 1'b1;
    end else begin
      unique case (cmd.kind)
        KIND_COMMAND, KIND_DATA: begin
          mode_nxt  = MODE_SINGLE;
          idx_nxt   = 4'd0;
          sel_nxt   = (cmd.kind == KIND_DATA);
          start     = 1'b1;
          start_val = cmd.byte_val;
        end
        KIND_INIT: begin
          mode_nxt  = MODE_INIT;
          idx_nxt   = 4'd0;
          en_nxt    = 1'b0;
          phase_nxt = PH_POWER;
          // With no power-up wait the first init command starts at once.
          if (power_r == 16'd0) begin
            sel_nxt   = 1'b0;
            start     = 1'b1;
            start_val = init_byte(4'd0);
          end else begin
            wait_nxt = sat(power_r);
          end
        end
        KIND_GOTO: begin
          mode_nxt  = MODE_GOTO;
          idx_nxt   = 4'd0;
          sel_nxt   = 1'b0;
          start     = 1'b1;
          start_val = cmd.byte_val;
        end
        default: begin
          mode_nxt  = MODE_CLEAR;
          idx_nxt   = 4'd0;
          sel_nxt   = 1'b0;
          start     = 1'b1;
          start_val = CMD_CLEAR;
        end
      endcase
    end

    // End of a command gap: next byte of a clear or init, a last settle wait after the final init byte, or done.
    if (extra_go) begin
      priority if (mode_r == MODE_CLEAR && idx_r == 4'd0) begin
        idx_nxt   = 4'd1;
        start     = 1'b1;
        start_val = CMD_HOME;
      end else if (mode_r == MODE_INIT && (idx_r + 4'd1) < INIT_LEN) begin
        idx_nxt   = idx_r + 4'd1;
        start     = 1'b1;
        start_val = init_byte(idx_r + 4'd1);
      end else if (mode_r == MODE_INIT && (idx_r + 4'd1) == INIT_LEN) begin
        idx_nxt  = INIT_LEN;
        wait_nxt = sat(at_least_one(settle_r));
      end else begin
        phase_nxt = PH_IDLE;
        wait_nxt  = '0;
      end
    end

    if (start) begin
      byte_nxt  = start_val;
      nib_nxt   = start_val[7:4];
      en_nxt    = 1'b1;
      phase_nxt = PH_HI_EN;
      wait_nxt  = sat(at_least_one({8'h00, pulse_r}));
    end
  end

  assign res.data_nibble     = nib_nxt;
  assign res.register_select = sel_nxt;
  assign res.enable_line     = en_nxt;
  assign res.busy_res        = (phase_nxt != PH_IDLE);
  assign res.rejected        = rej;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r  <= 8'd1;
      gap_r    <= 16'd200;
      settle_r <= 16'd2000;
      cgap_r   <= 16'd100;
      power_r  <= 16'd20000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE_PULSE: pulse_r  <= cfg_data[7:0];
        REG_NIBBLE_GAP:   gap_r    <= cfg_data;
        REG_SETTLE:       settle_r <= cfg_data;
        REG_COMMAND_GAP:  cgap_r   <= cfg_data;
        REG_POWER_UP:     power_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      byte_r  <= 8'h00;
      mode_r  <= MODE_SINGLE;
      idx_r   <= 4'd0;
      nib_r   <= 4'd0;
      sel_r   <= 1'b0;
      en_r    <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      byte_r  <= byte_nxt;
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      nib_r   <= nib_nxt;
      sel_r   <= sel_nxt;
      en_r    <= en_nxt;
    end
  end

endmodule
